/* rtl/core/lru_key_value_cache_assert.svh */
// Assertion macros shared by the cache's checker.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// The consequent must hold at the same edge as the antecedent.
`define LKVC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lru cache check failed");

// The consequent must hold at the edge after the antecedent.
`define LKVC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lru cache check failed");

`endif

/* rtl/core/lkvc_pkg.sv */
// Types and constants shared by the LRU key/value cache.
package lkvc_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
    localparam logic [DATA_W-1:0] DATA_MISS = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                     cmd;
        logic signed [KEY_W-1:0]  key_in;
        logic signed [DATA_W-1:0] data_in;
    } t_in_word;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] data_out;
        logic                     evicted;
        logic signed [KEY_W-1:0]  evicted_key;
    } t_out_word;

endpackage

/* rtl/core/lkvc_lookup.sv */
// Parallel key match, victim search and free-entry search over all entries.
module lkvc_lookup #(
    parameter int MAX_ENTRIES = 16,
    parameter int RANK_W      = 4,
    parameter int OCC_W       = 5
) (
    input  logic [lkvc_pkg::KEY_W-1:0] i_keys [MAX_ENTRIES],
    input  logic [MAX_ENTRIES-1:0]     i_valid,
    input  logic [RANK_W-1:0]          i_ranks [MAX_ENTRIES],
    input  logic [lkvc_pkg::KEY_W-1:0] i_key,
    input  logic [OCC_W-1:0]           i_occ,
    input  logic                       i_evict_en,
    output logic [MAX_ENTRIES-1:0]     o_match_oh,
    output logic [MAX_ENTRIES-1:0]     o_evict_oh,
    output logic [MAX_ENTRIES-1:0]     o_free_oh
);
    import lkvc_pkg::*;

    logic [MAX_ENTRIES-1:0] match_raw;
    logic [MAX_ENTRIES-1:0] evict_raw;
    logic [MAX_ENTRIES-1:0] evict_first;
    logic [MAX_ENTRIES-1:0] free_raw;
    logic [OCC_W-1:0]       oldest_rank;

    assign oldest_rank = i_occ - OCC_W'(1);

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match_raw[i] = i_valid[i] && (i_keys[i] == i_key);
            evict_raw[i] = i_valid[i] && (OCC_W'(i_ranks[i]) == oldest_rank);
        end
    end

    // x & -x keeps only the lowest set bit, which gives the lowest-indexed entry.
    assign o_match_oh  = match_raw & (~match_raw + MAX_ENTRIES'(1));
    assign evict_first = evict_raw & (~evict_raw + MAX_ENTRIES'(1));
    assign o_evict_oh  = i_evict_en ? evict_first : '0;

    // The victim's entry counts as free for the insertion that follows.
    assign free_raw  = ~(i_valid & ~o_evict_oh);
    assign o_free_oh = free_raw & (~free_raw + MAX_ENTRIES'(1));

endmodule

/* rtl/core/lru_key_value_cache.sv */
// Fully associative key/value cache with least-recently-used replacement.
// A word is accepted every clock cycle while the input is not stalled: the word is
// captured in the input register, passes through the per-entry key comparators and
// rank updaters, and lands in the result register once it is free or draining.
// Each entry holds a
// recency rank (0 is most recent); a put on an absent key evicts the entry whose
// rank is occupancy - 1 once occupancy has reached the configured capacity, and
// fills the lowest-indexed free entry. Capacity writes of zero act as one, and
// values above MAX_ENTRIES saturate. Throughput is limited only by the output
// side: while a result is stalled, one further word is held in the input
// register.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lkvc_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  lkvc_pkg::t_in_word         i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output lkvc_pkg::t_out_word        o_out_word
);
    import lkvc_pkg::*;

    localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;

    logic [KEY_W-1:0]       r_keys [MAX_ENTRIES];
    logic [DATA_W-1:0]      r_vals [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [RANK_W-1:0]      r_rank [MAX_ENTRIES];
    logic [OCC_W-1:0]       r_occ;
    logic [CFG_W-1:0]       r_cfg;

    logic                   r_in_valid;
    t_in_word               r_in;
    logic                   r_out_valid;
    t_out_word              r_out;

    logic [MAX_ENTRIES-1:0] n_valid;
    logic [RANK_W-1:0]      n_rank [MAX_ENTRIES];
    logic [OCC_W-1:0]       n_occ;
    t_out_word              n_out;

    logic                   fire;
    logic                   is_put;
    logic                   hit;
    logic                   evict_en;
    logic                   evicted;
    logic                   insert;
    logic [CMP_W-1:0]       cap;
    logic [MAX_ENTRIES-1:0] match_oh;
    logic [MAX_ENTRIES-1:0] evict_oh;
    logic [MAX_ENTRIES-1:0] free_oh;
    logic [RANK_W-1:0]      hit_rank;
    logic [DATA_W-1:0]      hit_val;
    logic [KEY_W-1:0]       evict_key;

    // Handshake: the lookup stage moves when the result register is free or draining.
    assign fire        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !fire;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        if (r_cfg == '0) begin
            cap = CMP_W'(1);
        end else if (CMP_W'(r_cfg) > CMP_W'(MAX_ENTRIES)) begin
            cap = CMP_W'(MAX_ENTRIES);
        end else begin
            cap = CMP_W'(r_cfg);
        end
    end

    assign is_put   = (r_in.cmd == CMD_PUT);
    assign evict_en = is_put && !hit && (CMP_W'(r_occ) >= cap);

    lkvc_lookup #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .RANK_W      (RANK_W),
        .OCC_W       (OCC_W)
    ) u_lookup (
        .i_keys     (r_keys),
        .i_valid    (r_valid),
        .i_ranks    (r_rank),
        .i_key      (r_in.key_in),
        .i_occ      (r_occ),
        .i_evict_en (evict_en),
        .o_match_oh (match_oh),
        .o_evict_oh (evict_oh),
        .o_free_oh  (free_oh)
    );

    assign hit     = |match_oh;
    assign evicted = |evict_oh;
    assign insert  = is_put && !hit && (|free_oh);

    always_comb begin
        hit_rank  = '0;
        hit_val   = '0;
        evict_key = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit_rank  = hit_rank  | ({RANK_W{match_oh[i]}} & r_rank[i]);
            hit_val   = hit_val   | ({DATA_W{match_oh[i]}} & r_vals[i]);
            evict_key = evict_key | ({KEY_W{evict_oh[i]}} & r_keys[i]);
        end
    end

    // A hit ages only the entries more recent than it; an insertion ages every survivor.
    always_comb begin
        n_valid = (r_valid & ~evict_oh) | ({MAX_ENTRIES{insert}} & free_oh);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (hit) begin
                if (match_oh[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end else if (insert) begin
                if (free_oh[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && !evict_oh[i]) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end
        end
        n_occ = r_occ - OCC_W'(evicted) + OCC_W'(insert);
    end

    always_comb begin
        n_out.hit         = hit;
        n_out.data_out    = is_put ? r_in.data_in : (hit ? hit_val : DATA_MISS);
        n_out.evicted     = evicted;
        n_out.evicted_key = evict_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_occ       <= '0;
            r_cfg       <= CFG_RESET;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (fire) begin
                r_valid <= n_valid;
                r_occ   <= n_occ;
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    r_rank[i] <= n_rank[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_word;
        end
        if (fire) begin
            r_out <= n_out;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (insert && free_oh[i]) begin
                    r_keys[i] <= r_in.key_in;
                    r_vals[i] <= r_in.data_in;
                end else if (hit && is_put && match_oh[i]) begin
                    r_vals[i] <= r_in.data_in;
                end
            end
        end
    end

endmodule

/* rtl/core/lkvc_checker.sv */
// Port-level checks on the LRU cache, bound to the top level.
`include "lru_key_value_cache_assert.svh"

module lkvc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input lkvc_pkg::t_in_word         i_in_word,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input lkvc_pkg::t_out_word        o_out_word
);
    import lkvc_pkg::*;

    // A stalled input word stays offered and unchanged.
    `LKVC_ASSERT_NEXT(a_in_hold, i_in_valid && o_in_stall, i_in_valid && $stable(i_in_word))

    // A stalled result word stays put.
    `LKVC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))

    // The input side only backs up when the result register is full and blocked.
    `LKVC_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // Only a put on an absent key can evict.
    `LKVC_ASSERT_NOW(a_evict_miss, o_out_valid && o_out_word.evicted, !o_out_word.hit)

    // Without an eviction the reported key is zero.
    `LKVC_ASSERT_NOW(a_evict_key_zero, o_out_valid && !o_out_word.evicted,
        o_out_word.evicted_key == '0)

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
